>>> design/mi3_pkg.sv
package mi3_pkg;

   localparam int EntryWidth = 16;
   localparam int ResultWidth = 32;
   localparam int CofWidth = 34;
   localparam int DetWidth = 52;
   localparam int NumWidth = CofWidth + 24;
   localparam int QuotWidth = NumWidth;
   localparam int Entries = 9;
   localparam int QueueDepth = 4;

   typedef logic signed [EntryWidth-1:0] entry_type;
   typedef logic signed [ResultWidth-1:0] result_type;
   typedef logic signed [CofWidth-1:0] cof_type;
   typedef logic signed [DetWidth-1:0] det_type;

   // one classified matrix handed from front to back
   typedef struct packed {
      cof_type [Entries-1:0] cof;
      det_type det;
      logic singular;
   } job_type;

   function automatic result_type sat_q16(input logic signed [QuotWidth-1:0] v);
      logic signed [QuotWidth-1:0] hi;
      logic signed [QuotWidth-1:0] lo;
      hi = QuotWidth'(64'sd2147483647);
      lo = -QuotWidth'(64'sd2147483648);
      if (v > hi) begin
         return result_type'(32'sh7fffffff);
      end else if (v < lo) begin
         return result_type'(32'sh80000000);
      end
      return v[ResultWidth-1:0];
   endfunction

endpackage

>>> design/matrix_inverse_3x3.sv
// channel  | ports                      | transfer when
// request  | req_valid/req_ready, req_* | req_valid && req_ready
// response | rsp_valid/rsp_ready, rsp_* | rsp_valid && rsp_ready
//
// one matrix per cycle sustained while rsp_ready stays high; the path is
// 4 front stages, the queue, and 59 back stages
// (magnitudes, then 58 divider stages of one quotient bit each, nine lanes).
// reset clears the valid bits, the queue pointers and the queue count only.
// a stall at rsp_ready backs up through the divider into the queue; the
// front keeps filling the queue until it is full.
module matrix_inverse_3x3 #(
   parameter int QueueDepth = mi3_pkg::QueueDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_in_r0c0,
   input  logic signed [15:0] req_in_r1c0,
   input  logic signed [15:0] req_in_r2c0,
   input  logic signed [15:0] req_in_r0c1,
   input  logic signed [15:0] req_in_r1c1,
   input  logic signed [15:0] req_in_r2c1,
   input  logic signed [15:0] req_in_r0c2,
   input  logic signed [15:0] req_in_r1c2,
   input  logic signed [15:0] req_in_r2c2,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_inv_r0c0,
   output logic signed [31:0] rsp_inv_r1c0,
   output logic signed [31:0] rsp_inv_r2c0,
   output logic signed [31:0] rsp_inv_r0c1,
   output logic signed [31:0] rsp_inv_r1c1,
   output logic signed [31:0] rsp_inv_r2c1,
   output logic signed [31:0] rsp_inv_r0c2,
   output logic signed [31:0] rsp_inv_r1c2,
   output logic signed [31:0] rsp_inv_r2c2,
   output logic rsp_singular
);
   import mi3_pkg::*;

   entry_type [Entries-1:0] m;
   job_type fj, qj;
   logic fv, fr, qv, qr;
   result_type [Entries-1:0] inv;

   assign m = {req_in_r2c2, req_in_r1c2, req_in_r0c2, req_in_r2c1, req_in_r1c1,
               req_in_r0c1, req_in_r2c0, req_in_r1c0, req_in_r0c0};

   mi3_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .in_m(m),
      .job_valid(fv), .job_ready(fr), .job(fj)
   );

   mi3_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
      .rd_valid(qv), .rd_ready(qr), .rd_data(qj)
   );

   mi3_back u_back (
      .clock, .reset, .job_valid(qv), .job_ready(qr), .job(qj),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_inv(inv),
      .out_singular(rsp_singular)
   );

   assign rsp_inv_r0c0 = inv[0];
   assign rsp_inv_r1c0 = inv[1];
   assign rsp_inv_r2c0 = inv[2];
   assign rsp_inv_r0c1 = inv[3];
   assign rsp_inv_r1c1 = inv[4];
   assign rsp_inv_r2c1 = inv[5];
   assign rsp_inv_r0c2 = inv[6];
   assign rsp_inv_r1c2 = inv[7];
   assign rsp_inv_r2c2 = inv[8];
endmodule

>>> design/mi3_front.sv
module mi3_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  mi3_pkg::entry_type [mi3_pkg::Entries-1:0] in_m,
   output logic job_valid,
   input  logic job_ready,
   output mi3_pkg::job_type job
);
   import mi3_pkg::*;

   // stage 1: products; stage 2: cofactors; stage 3: det products; stage 4: det sum
   logic [3:0] v_ff, v_in;
   logic signed [31:0] p_ff [18], p_in [18];
   cof_type [Entries-1:0] c2_ff, c2_in, c3_ff, c3_in;
   entry_type [2:0] e1_ff, e1_in, e2_ff, e2_in;
   logic signed [49:0] d_ff [3], d_in [3];
   job_type j_ff, j_in;
   logic adv;

   localparam int PI2 [36] = '{4,8,5,7, 2,7,1,8, 1,5,2,4, 5,6,3,8, 0,8,2,6,
                               2,3,0,5, 3,7,4,6, 1,6,0,7, 0,4,1,3};

   // the pipe moves as a whole; stalls only when the queue pushes back
   assign adv = job_ready || !v_ff[3];
   assign in_ready = adv;
   assign job_valid = v_ff[3];
   assign job = j_ff;

   logic signed [31:0] pr [9];
   logic signed [31:0] pr2 [9];
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         pr[k]  = 32'(in_m[PI2[4*k]]) * 32'(in_m[PI2[4*k+1]]);
         pr2[k] = 32'(in_m[PI2[4*k+2]]) * 32'(in_m[PI2[4*k+3]]);
      end
      for (int k = 0; k < 9; k++) begin
         p_in[2*k]   = pr[k];
         p_in[2*k+1] = pr2[k];
      end
      for (int k = 0; k < 9; k++) begin
         c2_in[k] = CofWidth'(p_ff[2*k]) - CofWidth'(p_ff[2*k+1]);
      end
      c3_in = c2_ff;
      e1_in = {in_m[2], in_m[1], in_m[0]};
      e2_in = e1_ff;
      d_in[0] = 50'(e2_ff[0]) * 50'(c2_ff[0]);
      d_in[1] = 50'(e2_ff[1]) * 50'(c2_ff[3]);
      d_in[2] = 50'(e2_ff[2]) * 50'(c2_ff[6]);
      j_in.cof = c3_ff;
      j_in.det = DetWidth'(d_ff[0]) + DetWidth'(d_ff[1]) + DetWidth'(d_ff[2]);
      j_in.singular = (j_in.det == '0);
      v_in = {v_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
      if (adv) begin
         p_ff <= p_in;
         c2_ff <= c2_in;
         c3_ff <= c3_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         d_ff <= d_in;
         j_ff <= j_in;
      end
   end
endmodule

>>> design/mi3_queue.sv
module mi3_queue #(
   parameter int Depth = mi3_pkg::QueueDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   output logic wr_ready,
   input  mi3_pkg::job_type wr_data,
   output logic rd_valid,
   input  logic rd_ready,
   output mi3_pkg::job_type rd_data
);
   import mi3_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   job_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push, pop;

   assign wr_ready = (cnt_ff != (AW+1)'(Depth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_comb begin
      wp_in = (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
      rp_in = (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_in;
         if (pop) rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= wr_data;
   end
endmodule

>>> design/mi3_back.sv
module mi3_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  mi3_pkg::job_type job,
   output logic out_valid,
   input  logic out_ready,
   output mi3_pkg::result_type [mi3_pkg::Entries-1:0] out_inv,
   output logic out_singular
);
   import mi3_pkg::*;

   // nine restoring dividers, one quotient bit per stage, fully pipelined
   localparam int Stages = QuotWidth;
   localparam int RW = DetWidth + 1;

   logic [Stages:0] v_ff;
   logic adv;
   logic [NumWidth-1:0] n_ff [Stages+1][Entries];
   logic [RW-1:0] r_ff [Stages][Entries];
   logic [Entries-1:0] neg_ff [Stages];
   logic [DetWidth-1:0] dm_ff [Stages];
   logic sg_ff [Stages+1];

   assign adv = out_ready || !v_ff[Stages];
   assign job_ready = adv;
   assign out_valid = v_ff[Stages];
   assign out_singular = sg_ff[Stages];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Stages-1:0], job_valid};
      end
   end

   // stage 0: magnitudes and signs
   always_ff @(posedge clock) begin
      if (adv) begin
         dm_ff[0] <= job.det[DetWidth-1] ? DetWidth'(-job.det) : DetWidth'(job.det);
         sg_ff[0] <= job.singular;
         for (int k = 0; k < Entries; k++) begin
            logic signed [NumWidth-1:0] num;
            num = {job.cof[k], 24'd0};
            n_ff[0][k] <= num[NumWidth-1] ? NumWidth'(-num) : NumWidth'(num);
            r_ff[0][k] <= '0;
            neg_ff[0][k] <= num[NumWidth-1] ^ job.det[DetWidth-1];
         end
      end
   end

   for (genvar s = 0; s < Stages-1; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            dm_ff[s+1] <= dm_ff[s];
            sg_ff[s+1] <= sg_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            for (int k = 0; k < Entries; k++) begin
               logic [RW:0] t;
               t = {r_ff[s][k], n_ff[s][k][NumWidth-1]};
               if (t >= {2'b0, dm_ff[s]}) begin
                  r_ff[s+1][k] <= RW'(t - {2'b0, dm_ff[s]});
                  n_ff[s+1][k] <= {n_ff[s][k][NumWidth-2:0], 1'b1};
               end else begin
                  r_ff[s+1][k] <= RW'(t);
                  n_ff[s+1][k] <= {n_ff[s][k][NumWidth-2:0], 1'b0};
               end
            end
         end
      end
   end

   // last bit, then sign and saturation
   always_ff @(posedge clock) begin
      if (adv) begin
         sg_ff[Stages] <= sg_ff[Stages-1];
         for (int k = 0; k < Entries; k++) begin
            logic [RW:0] t;
            logic [NumWidth-1:0] q;
            logic signed [QuotWidth:0] sq;
            t = {r_ff[Stages-1][k], n_ff[Stages-1][k][NumWidth-1]};
            q = {n_ff[Stages-1][k][NumWidth-2:0], (t >= {2'b0, dm_ff[Stages-1]})};
            sq = neg_ff[Stages-1][k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            n_ff[Stages][k] <= NumWidth'(sq[QuotWidth] ? (q > {1'b1, {(NumWidth-1){1'b0}}}
               ? {1'b1, {(NumWidth-1){1'b0}}} : NumWidth'(sq)) :
               (q[NumWidth-1] ? {1'b0, {(NumWidth-1){1'b1}}} : NumWidth'(sq)));
         end
      end
   end

   for (genvar k = 0; k < Entries; k++) begin : g_out
      assign out_inv[k] = sg_ff[Stages] ? '0 : sat_q16($signed(n_ff[Stages][k]));
   end
endmodule
